@@ src/lru_pkg.sv @@
package lru_pkg;

	localparam int NUM_FRAMES_DEF = 8;
	localparam int PAGE_BITS_DEF  = 16;
	localparam int STAMP_BITS_DEF = 32;

	localparam int PAGE_FIELD_W  = 16;
	localparam int FRAME_FIELD_W = 3;
	localparam int FAULT_W       = 32;
	localparam int CFG_W         = 4;
	localparam int IN_TDATA_W    = 16;
	localparam int OUT_TDATA_W   = 56;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [0:0]       REG_FRAMES_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] FRAMES_RESET      = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE
	} state_t;

endpackage

@@ src/lru_ram.sv @@
module lru_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/lru_page_replacement.sv @@
// an accepted input word is looked up by scanning the managed frames, where managed frames
// is frames_in_use held to 1..NUM_FRAMES, then drain and write states; the write waits while
// the last result word is stalled. A new word is taken only once the block is back in idle;
// the frame ram is scanned one frame per cycle through its single read port
// arst_n clears control state, empties all frames, zeroes both counters and sets
// frames_in_use to 8; a word with tlast set clears frames and counters after its result
module lru_page_replacement #(
	parameter int NUM_FRAMES = lru_pkg::NUM_FRAMES_DEF,
	parameter int PAGE_BITS  = lru_pkg::PAGE_BITS_DEF,
	parameter int STAMP_BITS = lru_pkg::STAMP_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lru_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lru_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lru_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [lru_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // page_number
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// frame_index, evicted_valid, evicted_page, fault_total, zero pad
	output logic [lru_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic [0:0]                       m_axis_tuser   // hit
);

	localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CNT_W = 7;
	localparam int RAM_W = PAGE_BITS + STAMP_BITS;
	localparam logic [CNT_W-1:0] NF_MAX = CNT_W'(NUM_FRAMES);

	lru_pkg::state_t state_q, state_d;

	logic [lru_pkg::CFG_W-1:0]   frames_q;
	logic [PAGE_BITS-1:0]        req_page_q;
	logic                        req_last_q;
	logic [STAMP_BITS-1:0]       step_q;
	logic [lru_pkg::FAULT_W-1:0] fault_q, fault_d;
	logic [NUM_FRAMES-1:0]       valid_q;
	logic [IDX_W-1:0]            idx_q;
	logic                        cmp_v_s1;
	logic [IDX_W-1:0]            cmp_idx_s1;
	logic                        found_q;
	logic [IDX_W-1:0]            hit_idx_q, min_idx_q;
	logic [STAMP_BITS-1:0]       min_stamp_q;
	logic                        min_valid_q;
	logic [PAGE_BITS-1:0]        min_page_q;

	logic                                  m_valid_q, m_hit_q, m_ev_valid_q;
	logic [lru_pkg::FRAME_FIELD_W-1:0]     m_frame_q;
	logic [lru_pkg::PAGE_FIELD_W-1:0]      m_ev_page_q;
	logic [lru_pkg::FAULT_W-1:0]           m_fault_q;

	logic                  cfg_wr, in_acc, ram_re, do_write, last_issue;
	logic [CNT_W-1:0]      cfg_ext, n_eff;
	logic [IDX_W-1:0]      pos;
	logic [RAM_W-1:0]      rd_data;
	logic [PAGE_BITS-1:0]  rd_page;
	logic [STAMP_BITS-1:0] rd_stamp, eff_stamp;
	logic                  rd_valid, page_eq, stamp_lt;
	logic [31:0]           in_ext, ev_ext;
	logic [7:0]            pos_ext;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == lru_pkg::REG_FRAMES_IN_USE) ?
		lru_pkg::APB_DATA_W'(frames_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= lru_pkg::FRAMES_RESET;
		end else if (cfg_wr && paddr[2] == lru_pkg::REG_FRAMES_IN_USE) begin
			frames_q <= pwdata[lru_pkg::CFG_W-1:0];
		end
	end

	// managed frame count, clamped to 1..NUM_FRAMES
	assign cfg_ext = CNT_W'(frames_q);
	assign n_eff = (cfg_ext == '0) ? CNT_W'(1) : ((cfg_ext > NF_MAX) ? NF_MAX : cfg_ext);
	assign last_issue = (CNT_W'(idx_q) == n_eff - CNT_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lru_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = lru_pkg::ST_SCAN;
				end
			end
			lru_pkg::ST_SCAN: begin
				if (last_issue) begin
					state_d = lru_pkg::ST_DRAIN;
				end
			end
			lru_pkg::ST_DRAIN: begin
				state_d = lru_pkg::ST_WRITE;
			end
			lru_pkg::ST_WRITE: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = lru_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lru_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		ram_re        = 1'b0;
		do_write      = 1'b0;
		case (state_q)
			lru_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			lru_pkg::ST_SCAN: begin
				ram_re = 1'b1;
			end
			lru_pkg::ST_DRAIN: begin
			end
			lru_pkg::ST_WRITE: begin
				do_write = !m_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lru_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// frame store: page and stamp in ram, valid bits in flops
	lru_ram #(
		.WIDTH(RAM_W),
		.DEPTH(NUM_FRAMES),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (do_write),
		.waddr(pos),
		.wdata({req_page_q, step_q}),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	// shared compare unit, one frame per cycle
	assign rd_page   = rd_data[RAM_W-1:STAMP_BITS];
	assign rd_stamp  = rd_data[STAMP_BITS-1:0];
	assign rd_valid  = valid_q[cmp_idx_s1];
	assign eff_stamp = rd_valid ? rd_stamp : '0;
	assign page_eq   = rd_valid && (rd_page == req_page_q);
	assign stamp_lt  = (cmp_idx_s1 == '0) || (eff_stamp < min_stamp_q);

	assign pos = found_q ? hit_idx_q : min_idx_q;

	assign fault_d = (!found_q && fault_q != '1) ? fault_q + 1'b1 : fault_q;

	assign in_ext  = 32'(s_axis_tdata);
	assign ev_ext  = 32'(min_page_q);
	assign pos_ext = 8'(pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= '0;
			fault_q   <= '0;
			valid_q   <= '0;
			idx_q     <= '0;
			cmp_v_s1  <= 1'b0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			cmp_v_s1 <= ram_re;
			if (in_acc) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				if (step_q != '1) begin
					step_q <= step_q + 1'b1;
				end
			end else if (ram_re) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmp_v_s1 && page_eq && !found_q) begin
				found_q <= 1'b1;
			end
			if (do_write) begin
				m_valid_q <= 1'b1;
				if (req_last_q) begin
					valid_q <= '0;
					step_q  <= '0;
					fault_q <= '0;
				end else begin
					valid_q[pos] <= 1'b1;
					fault_q      <= fault_d;
				end
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// search results and result word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_page_q <= in_ext[PAGE_BITS-1:0];
			req_last_q <= s_axis_tlast;
		end
		cmp_idx_s1 <= idx_q;
		if (cmp_v_s1) begin
			if (page_eq && !found_q) begin
				hit_idx_q <= cmp_idx_s1;
			end
			if (stamp_lt) begin
				min_idx_q   <= cmp_idx_s1;
				min_stamp_q <= eff_stamp;
				min_valid_q <= rd_valid;
				min_page_q  <= rd_page;
			end
		end
		if (do_write) begin
			m_hit_q      <= found_q;
			m_frame_q    <= pos_ext[lru_pkg::FRAME_FIELD_W-1:0];
			m_ev_valid_q <= !found_q && min_valid_q;
			m_ev_page_q  <= (!found_q && min_valid_q) ?
				ev_ext[lru_pkg::PAGE_FIELD_W-1:0] : '0;
			m_fault_q    <= fault_d;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_hit_q;
	assign m_axis_tdata  = {4'b0, m_fault_q, m_ev_page_q, m_ev_valid_q, m_frame_q};

endmodule

@@ src/lru_checker.sv @@
module lru_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lru_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]                      m_axis_tuser
);

	// a stalled result word stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	// one word in flight: no second input word right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");

	// a result needs at least the scan, drain and write cycles
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##1 !$rose(m_axis_tvalid) ##1 !$rose(m_axis_tvalid))
		else $error("result too early");

	// a hit never evicts
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[3])
		else $error("eviction reported on hit");

	// no eviction means zero evicted page
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[19:4] == 16'd0)
		else $error("evicted page not zero");

endmodule

bind lru_page_replacement lru_checker u_lru_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
